// ===== design/kalman_angle_bias_filter_defines.svh =====
// Assertion macros shared by the Kalman angle/bias filter modules.
`ifndef KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define KAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/kab_pkg.sv =====
// Shared types, constants and helper functions of the Kalman angle/bias filter.
package kab_pkg;
    localparam int CfgW = 31;
    localparam int AccW = 25;
    localparam int GyrW = 27;
    localparam int DataW = 32;
    localparam int IdxW = 2;
    localparam int ProdW = 64;
    localparam int Frac = 28;
    localparam int QuoW = 60;
    localparam int DivCntW = 6;

    localparam logic [IdxW-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [IdxW-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [IdxW-1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [IdxW-1:0] REG_PERIOD      = 2'd3;

    localparam logic signed [DataW-1:0] ONE_Q28 = 32'sh1000_0000;

    // Multiplier operand selects.
    typedef enum logic [3:0] {
        MA_RATE, MA_D00, MA_D01, MA_D11, MA_K0, MA_K1
    } t_mul_a;
    typedef enum logic [3:0] {
        MB_DT, MB_N00, MB_N01, MB_ERR
    } t_mul_b;
    // Destination of a finished rounded product (add or subtract, then saturate).
    typedef enum logic [3:0] {
        WB_ANGLE, WB_P00, WB_P01, WB_P10, WB_P11, WB_ANGLE_UPD, WB_BIAS,
        WB_C00, WB_C01, WB_C10, WB_C11
    } t_wb;

    typedef struct packed {
        logic   load;      // capture input item, compute rate
        logic   prep;      // compute d00, d01
        logic   mul;       // issue multiply
        t_mul_a mul_a;
        t_mul_b mul_b;
        logic   wb;        // write rounded product
        t_wb    wb_sel;
        logic   err;       // compute innovation and E
        logic   div_start;
        logic   div_sel;   // 0: gain k0, 1: gain k1
        logic   commit;    // copy updated state, latch result
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic e_pos;
    } t_sts;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
        logic signed [DataW-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
        else r = v[DataW-1:0];
        return r;
    endfunction
endpackage

// ===== design/kab_datapath.sv =====
// Datapath: state registers, shared multiplier with rounding, serial divider.
module kab_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kab_pkg::t_cmd                     i_cmd,
    output kab_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [kab_pkg::IdxW-1:0]          i_cfg_idx,
    input  logic [kab_pkg::CfgW-1:0]          i_cfg_data,
    input  logic signed [kab_pkg::AccW-1:0]   i_accel_angle,
    input  logic signed [kab_pkg::GyrW-1:0]   i_gyro_rate,
    output logic signed [kab_pkg::DataW-1:0]  o_angle_estimate,
    output logic signed [kab_pkg::DataW-1:0]  o_rate_corrected
);
    import kab_pkg::*;
    `include "kalman_angle_bias_filter_defines.svh"

    logic [CfgW-1:0] r_qa, r_qb, r_rm, r_dt;
    logic signed [DataW-1:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    // working copies
    logic signed [DataW-1:0] r_wang, r_wbias, r_n00, r_n01, r_n10, r_n11;
    logic signed [DataW-1:0] r_c00, r_c01, r_c10, r_c11;
    logic signed [DataW-1:0] r_rate, r_d00, r_d01, r_err, r_k0, r_k1;
    logic signed [AccW-1:0] r_acc;
    logic signed [GyrW-1:0] r_gyr;
    logic signed [ProdW-1:0] r_prod, r_e;
    logic signed [DataW-1:0] r_out_ang, r_out_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= 31'd268435;
            r_qb <= 31'd805306;
            r_rm <= 31'd134217728;
            r_dt <= 31'd1342177;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                REG_MEAS_NOISE:  r_rm <= i_cfg_data;
                REG_PERIOD:      r_dt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DataW-1:0] mul_a, mul_b;
    logic signed [ProdW-1:0] rnd;
    always_comb begin
        case (i_cmd.mul_a)
            MA_RATE: mul_a = r_rate;
            MA_D00:  mul_a = r_d00;
            MA_D01:  mul_a = r_d01;
            MA_D11:  mul_a = $signed({1'b0, r_qb});
            MA_K0:   mul_a = r_k0;
            MA_K1:   mul_a = r_k1;
            default: mul_a = '0;
        endcase
        case (i_cmd.mul_b)
            MB_DT:   mul_b = $signed({1'b0, r_dt});
            MB_N00:  mul_b = r_n00;
            MB_N01:  mul_b = r_n01;
            MB_ERR:  mul_b = r_err;
            default: mul_b = '0;
        endcase
        // Round half up, arithmetic shift is a floor.
        rnd = (r_prod + (64'sd1 <<< (Frac - 1))) >>> Frac;
    end

    // Serial restoring divider on magnitudes, 60 quotient bits.
    logic [QuoW-1:0] r_dq, r_dn;
    logic [QuoW:0]   r_rem;
    logic [DivCntW-1:0] r_dcnt;
    logic r_dbusy, r_dneg, r_dsel;
    logic [QuoW:0] rem_sh, rem_sub;
    logic [QuoW-1:0] e_mag;
    always_comb begin
        e_mag = r_e[QuoW-1:0];
        rem_sh = {r_rem[QuoW-1:0], r_dn[QuoW-1]};
        rem_sub = rem_sh - {1'b0, e_mag};
    end

    logic signed [DataW-1:0] num;
    logic signed [ProdW-1:0] nume;
    always_comb begin
        num = i_cmd.div_sel ? r_n10 : r_n00;
        nume = {{(ProdW-DataW){num[DataW-1]}}, num} <<< Frac;
    end

    // Signed quotient including the last quotient bit.
    function automatic logic signed [ProdW-1:0] quo_s_last(input logic neg,
            input logic [QuoW-1:0] q, input logic bitv);
        logic [QuoW-1:0] qq;
        qq = {q[QuoW-2:0], bitv};
        return neg ? -$signed({4'd0, qq}) : $signed({4'd0, qq});
    endfunction

    logic signed [ProdW-1:0] x_rate, x_d00, x_err, x_e;
    always_comb begin
        x_rate = ProdW'(i_gyro_rate) - ProdW'(r_bias);
        x_d00  = $signed({33'd0, r_qa}) - ProdW'(r_p01) - ProdW'(r_p10);
        x_err  = ProdW'(r_acc) - ProdW'(r_wang);
        x_e    = $signed({33'd0, r_rm}) + ProdW'(r_n00);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DivCntW'(QuoW - 1);
        end else if (r_dbusy) begin
            if (r_dcnt == '0) r_dbusy <= 1'b0;
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dn   <= nume[ProdW-1] ? QuoW'(-nume) : nume[QuoW-1:0];
            r_dneg <= nume[ProdW-1];
            r_dsel <= i_cmd.div_sel;
            r_rem  <= '0;
            r_dq   <= '0;
        end else if (r_dbusy) begin
            r_dn <= {r_dn[QuoW-2:0], 1'b0};
            if (!rem_sub[QuoW]) begin
                r_rem <= rem_sub;
                r_dq  <= {r_dq[QuoW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dq  <= {r_dq[QuoW-2:0], 1'b0};
            end
            if (r_dcnt == '0) begin
                if (r_dsel) r_k1 <= sat32(quo_s_last(r_dneg, r_dq, !rem_sub[QuoW]));
                else        r_k0 <= sat32(quo_s_last(r_dneg, r_dq, !rem_sub[QuoW]));
            end
        end
        if (i_cmd.err && !(x_e > 0)) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= ONE_Q28;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= ONE_Q28;
        end else if (i_cmd.commit) begin
            r_ang  <= r_wang;
            r_bias <= r_wbias;
            r_p00  <= r_c00;
            r_p01  <= r_c01;
            r_p10  <= r_c10;
            r_p11  <= r_c11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc  <= i_accel_angle;
            r_gyr  <= i_gyro_rate;
            r_rate <= sat32(x_rate);
            r_wang <= r_ang;
            r_wbias <= r_bias;
        end
        if (i_cmd.prep) begin
            r_d00 <= sat32(x_d00);
            r_d01 <= sat32(-ProdW'(r_p11));
        end
        if (i_cmd.mul) r_prod <= ProdW'(mul_a) * ProdW'(mul_b);
        if (i_cmd.err) begin
            r_err <= sat32(x_err);
            r_e   <= x_e;
        end
        if (i_cmd.wb) begin
            case (i_cmd.wb_sel)
                WB_ANGLE, WB_ANGLE_UPD: r_wang <= sat32(ProdW'(r_wang) + rnd);
                WB_P00:  r_n00 <= sat32(ProdW'(r_p00) + rnd);
                WB_P01:  r_n01 <= sat32(ProdW'(r_p01) + rnd);
                WB_P10:  r_n10 <= sat32(ProdW'(r_p10) + rnd);
                WB_P11:  r_n11 <= sat32(ProdW'(r_p11) + rnd);
                WB_BIAS: r_wbias <= sat32(ProdW'(r_wbias) + rnd);
                WB_C00:  r_c00 <= sat32(ProdW'(r_n00) - rnd);
                WB_C01:  r_c01 <= sat32(ProdW'(r_n01) - rnd);
                WB_C10:  r_c10 <= sat32(ProdW'(r_n10) - rnd);
                WB_C11:  r_c11 <= sat32(ProdW'(r_n11) - rnd);
                default: ;
            endcase
        end
        if (i_cmd.commit) begin
            r_out_ang  <= r_wang;
            r_out_rate <= sat32(ProdW'(r_gyr) - ProdW'(r_wbias));
        end
    end

    assign o_sts.div_busy = r_dbusy;
    assign o_sts.e_pos    = (r_e > 0);
    assign o_angle_estimate = r_out_ang;
    assign o_rate_corrected = r_out_rate;

    `KAB_ASSERT_IMP(a_div_idle_start, i_clk, i_rst_n, i_cmd.div_start, !r_dbusy)
    `KAB_ASSERT_NXT(a_div_runs, i_clk, i_rst_n, i_cmd.div_start, r_dbusy)
    `KAB_ASSERT_IMP(a_no_commit_busy, i_clk, i_rst_n, i_cmd.commit, !r_dbusy)
endmodule

// ===== design/kab_ctrl.sv =====
// Controller: sequences predict and update steps and runs the handshakes.
module kab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  kab_pkg::t_sts i_sts,
    output kab_pkg::t_cmd o_cmd
);
    import kab_pkg::*;
    `include "kalman_angle_bias_filter_defines.svh"

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_MUL  = 6'b000100,
        S_WB   = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic r_ovalid, n_ovalid;

    // Multiply program: step -> operands and destination.
    t_mul_a ma;
    t_mul_b mb;
    t_wb    wsel;
    always_comb begin
        ma = MA_RATE; mb = MB_DT; wsel = WB_ANGLE;
        case (r_step)
            4'd0:  begin ma = MA_RATE; mb = MB_DT;  wsel = WB_ANGLE; end
            4'd1:  begin ma = MA_D00;  mb = MB_DT;  wsel = WB_P00; end
            4'd2:  begin ma = MA_D01;  mb = MB_DT;  wsel = WB_P01; end
            4'd3:  begin ma = MA_D01;  mb = MB_DT;  wsel = WB_P10; end
            4'd4:  begin ma = MA_D11;  mb = MB_DT;  wsel = WB_P11; end
            4'd5:  begin ma = MA_K0;   mb = MB_N00; wsel = WB_C00; end
            4'd6:  begin ma = MA_K0;   mb = MB_N01; wsel = WB_C01; end
            4'd7:  begin ma = MA_K1;   mb = MB_N00; wsel = WB_C10; end
            4'd8:  begin ma = MA_K1;   mb = MB_N01; wsel = WB_C11; end
            4'd9:  begin ma = MA_K0;   mb = MB_ERR; wsel = WB_ANGLE_UPD; end
            4'd10: begin ma = MA_K1;   mb = MB_ERR; wsel = WB_BIAS; end
            default: ;
        endcase
    end

    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd = '0;
        o_cmd.mul_a = ma;
        o_cmd.mul_b = mb;
        o_cmd.wb_sel = wsel;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_PREP;
                n_step = '0;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_step = r_step + 4'd1;
                if (r_step == 4'd4) begin
                    n_state = S_DIV;
                end else if (r_step == 4'd10) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                // Sub-steps: 5 = innovation, 6 = gain k0, 7 = gain k1.
                if (r_step == 4'd5) begin
                    o_cmd.err = 1'b1;
                    n_step = 4'd6;
                end else if (!i_sts.div_busy) begin
                    if (r_step == 4'd6 && i_sts.e_pos) begin
                        o_cmd.div_start = 1'b1;
                        n_step = 4'd7;
                    end else if (r_step == 4'd7 && i_sts.e_pos) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel = 1'b1;
                        n_step = 4'd8;
                    end else begin
                        n_step = 4'd5;
                        n_state = S_MUL;
                    end
                end
            end
            S_DONE: if (out_free) begin
                o_cmd.commit = 1'b1;
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    `KAB_ASSERT_IMP(a_commit_done, i_clk, i_rst_n, o_cmd.commit, r_state == S_DONE)
    `KAB_ASSERT_NXT(a_load_leaves_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_PREP)
    `KAB_ASSERT_IMP(a_hold_result, i_clk, i_rst_n, r_ovalid && !i_out_ready, !o_cmd.commit)
endmodule

// ===== design/kalman_angle_bias_filter.sv =====
// Top level of the two-state tilt Kalman filter (angle and gyro bias).
// One input transfer carries an accelerometer angle and a gyro rate; the block
// runs the predict and update steps of a 2x2 Kalman filter and produces one
// result transfer with the filtered angle and the bias-corrected rate, both
// signed Q4.28 and saturated. Work runs through one shared 32x32 multiplier
// (a multiply state and a rounding write-back state per product, eleven
// products) and a radix-2 serial divider for each of the two gains. One item
// is processed at a time; a finished result waits in an output register while
// the next item may already be accepted. When the innovation variance is not
// positive, both gains are zero and the divider is skipped. Configuration
// registers are written through a plain write port and must only be written
// while the block is idle.
module kalman_angle_bias_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kab_pkg::IdxW-1:0]          i_cfg_idx,
    input  logic [kab_pkg::CfgW-1:0]          i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [kab_pkg::AccW-1:0]   i_accel_angle,
    input  logic signed [kab_pkg::GyrW-1:0]   i_gyro_rate,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [kab_pkg::DataW-1:0]  o_angle_estimate,
    output logic signed [kab_pkg::DataW-1:0]  o_rate_corrected
);
    import kab_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer for both filter steps.
    kab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // State, multiplier, divider and result register.
    kab_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_accel_angle    (i_accel_angle),
        .i_gyro_rate      (i_gyro_rate),
        .o_angle_estimate (o_angle_estimate),
        .o_rate_corrected (o_rate_corrected)
    );
endmodule
